### rtl/eatr_pkg.sv
// Package: shared types, constants and fixed-point helpers for the rotation matrix unit.
package eatr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int FX_W       = 16;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_ONE  = fx_t'(1 << FRAC_BITS);
  localparam fx_t FX_ZERO = '0;

  localparam logic [63:0] SIN_A = 64'd1686629713;
  localparam logic [63:0] SIN_B = 64'd688904866;
  localparam logic [63:0] SIN_C = 64'd76016977;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

  typedef enum logic [3:0] {
    CMD_X   = 4'd0,
    CMD_Y   = 4'd1,
    CMD_Z   = 4'd2,
    CMD_XYZ = 4'd3,
    CMD_XZY = 4'd4,
    CMD_YXZ = 4'd5,
    CMD_YZX = 4'd6,
    CMD_ZXY = 4'd7,
    CMD_ZYX = 4'd8
  } cmd_e;

  typedef struct packed {
    logic                  bad;
    cmd_e                  cmd;
    logic [ANGLE_BITS-1:0] ang_a;
    logic [ANGLE_BITS-1:0] ang_b;
    logic [ANGLE_BITS-1:0] ang_c;
  } item_t;

  // One matrix element is a*b + (c*d)*e, each product rounded.
  typedef struct packed {
    fx_t a;
    fx_t b;
    fx_t c;
    fx_t d;
    fx_t e;
  } term_t;

  function automatic fx_t mul2(fx_t x, fx_t y);
    logic [FX_W-1:0] mx;
    logic [FX_W-1:0] my;
    logic [2*FX_W-1:0] p;
    logic [2*FX_W-1:0] r;
    mx = x[FX_W-1] ? FX_W'(-x) : FX_W'(x);
    my = y[FX_W-1] ? FX_W'(-y) : FX_W'(y);
    p  = (2*FX_W)'(mx) * (2*FX_W)'(my);
    r  = (p + ((2*FX_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (x[FX_W-1] ^ y[FX_W-1]) ? -fx_t'(r[FX_W-1:0]) : fx_t'(r[FX_W-1:0]);
  endfunction

  function automatic fx_t clampfx(logic signed [FX_W:0] v);
    if (v > (FX_W+1)'(FX_ONE)) begin
      return FX_ONE;
    end else if (v < -(FX_W+1)'(FX_ONE)) begin
      return -FX_ONE;
    end
    return fx_t'(v);
  endfunction

  function automatic term_t tx(fx_t a, fx_t b);
    term_t t;
    t.a = a;
    t.b = b;
    t.c = FX_ZERO;
    t.d = FX_ZERO;
    t.e = FX_ZERO;
    return t;
  endfunction

  function automatic term_t tv(fx_t v);
    return tx(v, FX_ONE);
  endfunction

  function automatic term_t tt(fx_t p, fx_t q, fx_t r, fx_t u, fx_t v);
    term_t t;
    t.a = u;
    t.b = v;
    t.c = p;
    t.d = q;
    t.e = r;
    return t;
  endfunction

endpackage

### rtl/eatr_front.sv
// Front stage: takes commands, classifies them and hands items to the queue.
module eatr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      cmd,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] angle_a,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] angle_b,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] angle_c,
  input  logic                            full,
  output logic                            push,
  output eatr_pkg::item_t                 item
);

  logic fv;
  logic fv_next;
  logic take;

  assign busy = fv & full;
  assign push = fv & ~full;
  assign take = start & ~busy;

  always_comb begin
    fv_next = fv;
    if (take) begin
      fv_next = 1'b1;
    end else if (push) begin
      fv_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= fv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.bad   <= (cmd > 4'(eatr_pkg::CMD_ZYX));
      item.cmd   <= eatr_pkg::cmd_e'(cmd);
      item.ang_a <= angle_a;
      item.ang_b <= angle_b;
      item.ang_c <= angle_c;
    end
  end

endmodule

### rtl/eatr_fifo.sv
// Two-entry queue between the front stage and the arithmetic back end.
module eatr_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  eatr_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output eatr_pkg::item_t rd_item
);

  eatr_pkg::item_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic [1:0] cnt_next;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign rd_item = mem[rp];

  always_comb begin
    cnt_next = cnt;
    if (push && !(pop && valid)) begin
      cnt_next = cnt + 2'd1;
    end else if (!push && pop && valid) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wp <= ~wp;
      end
      if (pop && valid) begin
        rp <= ~rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

endmodule

### rtl/eatr_sine.sv
// Pipelined fixed-point sine of a binary angle, four register stages.
module eatr_sine (
  input  logic                            clk,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] ang,
  output eatr_pkg::fx_t                   sin_out
);

  localparam int QB = eatr_pkg::ANGLE_BITS - 2;

  logic [1:0]  q;
  logic [QB:0] f;
  logic [QB:0] fm;
  logic [30:0] z;

  logic [30:0] z_1, z_2, z_3;
  logic [30:0] z2_1, z2_2;
  logic        neg_1, neg_2, neg_3;
  logic [29:0] t_2;
  logic [30:0] t_3;

  logic [63:0] p1, p2, p3, p4;
  logic [63:0] m;

  assign q  = ang[eatr_pkg::ANGLE_BITS-1 -: 2];
  assign f  = {1'b0, ang[QB-1:0]};
  assign fm = q[0] ? ((QB+1)'(eatr_pkg::QUARTER_TURN) - f) : f;
  assign z  = 31'(fm) << (32 - eatr_pkg::ANGLE_BITS);

  assign p1 = 64'(z) * 64'(z);
  assign p2 = eatr_pkg::SIN_C * 64'(z2_1);
  assign p3 = 64'(t_2) * 64'(z2_2);
  assign p4 = 64'(t_3) * 64'(z_3);
  assign m  = ((p4 >> 30) + (64'd1 << (29 - eatr_pkg::FRAC_BITS)))
              >> (30 - eatr_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    z2_1  <= 31'(p1 >> 30);
    z_1   <= z;
    neg_1 <= q[1];

    t_2   <= 30'(eatr_pkg::SIN_B - (p2 >> 30));
    z2_2  <= z2_1;
    z_2   <= z_1;
    neg_2 <= neg_1;

    t_3   <= 31'(eatr_pkg::SIN_A - (p3 >> 30));
    z_3   <= z_2;
    neg_3 <= neg_2;

    if (m > 64'(eatr_pkg::FX_ONE)) begin
      sin_out <= neg_3 ? -eatr_pkg::FX_ONE : eatr_pkg::FX_ONE;
    end else begin
      sin_out <= neg_3 ? -eatr_pkg::fx_t'(m[eatr_pkg::FX_W-1:0])
                       : eatr_pkg::fx_t'(m[eatr_pkg::FX_W-1:0]);
    end
  end

endmodule

### rtl/eatr_back.sv
// Back end: sines and cosines, factor selection, products, sums and clamping.
module eatr_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  input  eatr_pkg::item_t                 item,
  output logic                            pop,
  output logic                            strobe,
  output eatr_pkg::fx_t [8:0]             res_m,
  output logic                            res_bad
);

  eatr_pkg::fx_t sx, cx, sy, cy, sz, cz;
  eatr_pkg::fx_t nsx, nsy, nsz;

  logic [3:0]       vld;
  eatr_pkg::cmd_e   cmd_d [4];
  logic             bad_d [4];

  eatr_pkg::term_t  sel [9];
  eatr_pkg::term_t  sel_r [9];
  logic             vld4, vld5, vld6;
  logic             bad4, bad5, bad6;
  eatr_pkg::fx_t    p1_5 [9];
  eatr_pkg::fx_t    p2_5 [9];
  eatr_pkg::fx_t    e_5  [9];
  eatr_pkg::fx_t    p1_6 [9];
  eatr_pkg::fx_t    p3_6 [9];

  assign pop = valid;

  eatr_sine u_sx (.clk(clk), .ang(item.ang_a), .sin_out(sx));
  eatr_sine u_cx (.clk(clk), .ang(item.ang_a + eatr_pkg::QUARTER_TURN), .sin_out(cx));
  eatr_sine u_sy (.clk(clk), .ang(item.ang_b), .sin_out(sy));
  eatr_sine u_cy (.clk(clk), .ang(item.ang_b + eatr_pkg::QUARTER_TURN), .sin_out(cy));
  eatr_sine u_sz (.clk(clk), .ang(item.ang_c), .sin_out(sz));
  eatr_sine u_cz (.clk(clk), .ang(item.ang_c + eatr_pkg::QUARTER_TURN), .sin_out(cz));

  assign nsx = -sx;
  assign nsy = -sy;
  assign nsz = -sz;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      sel[i] = eatr_pkg::tx(eatr_pkg::FX_ZERO, eatr_pkg::FX_ZERO);
    end
    sel[0] = eatr_pkg::tv(eatr_pkg::FX_ONE);
    sel[4] = eatr_pkg::tv(eatr_pkg::FX_ONE);
    sel[8] = eatr_pkg::tv(eatr_pkg::FX_ONE);
    case (cmd_d[3])
      eatr_pkg::CMD_X: begin
        sel[4] = eatr_pkg::tv(cx);
        sel[5] = eatr_pkg::tv(sx);
        sel[7] = eatr_pkg::tv(nsx);
        sel[8] = eatr_pkg::tv(cx);
      end
      eatr_pkg::CMD_Y: begin
        sel[0] = eatr_pkg::tv(cx);
        sel[2] = eatr_pkg::tv(nsx);
        sel[6] = eatr_pkg::tv(sx);
        sel[8] = eatr_pkg::tv(cx);
      end
      eatr_pkg::CMD_Z: begin
        sel[0] = eatr_pkg::tv(cx);
        sel[1] = eatr_pkg::tv(sx);
        sel[3] = eatr_pkg::tv(nsx);
        sel[4] = eatr_pkg::tv(cx);
      end
      eatr_pkg::CMD_XYZ: begin
        sel[0] = eatr_pkg::tx(cy, cz);
        sel[1] = eatr_pkg::tx(cy, sz);
        sel[2] = eatr_pkg::tv(nsy);
        sel[3] = eatr_pkg::tt(sx, sy, cz, cx, nsz);
        sel[4] = eatr_pkg::tt(sx, sy, sz, cx, cz);
        sel[5] = eatr_pkg::tx(sx, cy);
        sel[6] = eatr_pkg::tt(cx, sy, cz, sx, sz);
        sel[7] = eatr_pkg::tt(cx, sy, sz, nsx, cz);
        sel[8] = eatr_pkg::tx(cx, cy);
      end
      eatr_pkg::CMD_XZY: begin
        sel[0] = eatr_pkg::tx(cz, cy);
        sel[1] = eatr_pkg::tv(sz);
        sel[2] = eatr_pkg::tx(cz, nsy);
        sel[3] = eatr_pkg::tt(cx, nsz, cy, sx, sy);
        sel[4] = eatr_pkg::tx(cx, cz);
        sel[5] = eatr_pkg::tt(cx, nsz, nsy, sx, cy);
        sel[6] = eatr_pkg::tt(nsx, nsz, cy, cx, sy);
        sel[7] = eatr_pkg::tx(nsx, cz);
        sel[8] = eatr_pkg::tt(nsx, nsz, nsy, cx, cy);
      end
      eatr_pkg::CMD_YXZ: begin
        sel[0] = eatr_pkg::tt(nsy, nsx, nsz, cy, cz);
        sel[1] = eatr_pkg::tt(nsy, nsx, cz, cy, sz);
        sel[2] = eatr_pkg::tx(nsy, cx);
        sel[3] = eatr_pkg::tx(cx, nsz);
        sel[4] = eatr_pkg::tx(cx, cz);
        sel[5] = eatr_pkg::tv(sx);
        sel[6] = eatr_pkg::tt(cy, nsx, nsz, sy, cz);
        sel[7] = eatr_pkg::tt(cy, nsx, cz, sy, sz);
        sel[8] = eatr_pkg::tx(cy, cx);
      end
      eatr_pkg::CMD_YZX: begin
        sel[0] = eatr_pkg::tx(cy, cz);
        sel[1] = eatr_pkg::tt(cy, sz, cx, nsy, nsx);
        sel[2] = eatr_pkg::tt(cy, sz, sx, nsy, cx);
        sel[3] = eatr_pkg::tv(nsz);
        sel[4] = eatr_pkg::tx(cz, cx);
        sel[5] = eatr_pkg::tx(cz, sx);
        sel[6] = eatr_pkg::tx(sy, cz);
        sel[7] = eatr_pkg::tt(sy, sz, cx, cy, nsx);
        sel[8] = eatr_pkg::tt(sy, sz, sx, cy, cx);
      end
      eatr_pkg::CMD_ZXY: begin
        sel[0] = eatr_pkg::tt(sz, sx, sy, cz, cy);
        sel[1] = eatr_pkg::tx(sz, cx);
        sel[2] = eatr_pkg::tt(sz, sx, cy, cz, nsy);
        sel[3] = eatr_pkg::tt(cz, sx, sy, nsz, cy);
        sel[4] = eatr_pkg::tx(cz, cx);
        sel[5] = eatr_pkg::tt(cz, sx, cy, nsz, nsy);
        sel[6] = eatr_pkg::tx(cx, sy);
        sel[7] = eatr_pkg::tv(nsx);
        sel[8] = eatr_pkg::tx(cx, cy);
      end
      eatr_pkg::CMD_ZYX: begin
        sel[0] = eatr_pkg::tx(cz, cy);
        sel[1] = eatr_pkg::tt(cz, nsy, nsx, sz, cx);
        sel[2] = eatr_pkg::tt(cz, nsy, cx, sz, sx);
        sel[3] = eatr_pkg::tx(nsz, cy);
        sel[4] = eatr_pkg::tt(nsz, nsy, nsx, cz, cx);
        sel[5] = eatr_pkg::tt(nsz, nsy, cx, cz, sx);
        sel[6] = eatr_pkg::tv(sy);
        sel[7] = eatr_pkg::tx(cy, nsx);
        sel[8] = eatr_pkg::tx(cy, cx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      vld4   <= 1'b0;
      vld5   <= 1'b0;
      vld6   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      vld    <= {vld[2:0], valid};
      vld4   <= vld[3];
      vld5   <= vld4;
      vld6   <= vld5;
      strobe <= vld6;
    end
  end

  always_ff @(posedge clk) begin
    cmd_d[0] <= item.cmd;
    bad_d[0] <= item.bad;
    for (int i = 1; i < 4; i++) begin
      cmd_d[i] <= cmd_d[i-1];
      bad_d[i] <= bad_d[i-1];
    end
    bad4 <= bad_d[3];
    bad5 <= bad4;
    bad6 <= bad5;
    res_bad <= bad6;
    for (int i = 0; i < 9; i++) begin
      sel_r[i] <= sel[i];
      p1_5[i]  <= eatr_pkg::mul2(sel_r[i].a, sel_r[i].b);
      p2_5[i]  <= eatr_pkg::mul2(sel_r[i].c, sel_r[i].d);
      e_5[i]   <= sel_r[i].e;
      p1_6[i]  <= p1_5[i];
      p3_6[i]  <= eatr_pkg::mul2(p2_5[i], e_5[i]);
      res_m[i] <= eatr_pkg::clampfx((eatr_pkg::FX_W+1)'(p1_6[i])
                                    + (eatr_pkg::FX_W+1)'(p3_6[i]));
    end
  end

endmodule

### rtl/euler_angles_to_rotation_matrix_unit.sv
// Top level: Euler-angle to 3x3 rotation matrix unit, Q2.14 results.
// A command is taken on any cycle where start is high and busy is low; one item
// per cycle is sustained, and busy stays low because the result side never stalls.
// Each item gives one result, shown for a single cycle with strobe high; the item
// passes the front register and the queue hand-off, the four-stage sine pipeline, a
// factor-select register and three product and clamp stages.
module euler_angles_to_rotation_matrix_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      cmd,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] angle_a,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] angle_b,
  input  logic [eatr_pkg::ANGLE_BITS-1:0] angle_c,
  output logic                            strobe,
  output logic signed [15:0]              r00,
  output logic signed [15:0]              r01,
  output logic signed [15:0]              r02,
  output logic signed [15:0]              r10,
  output logic signed [15:0]              r11,
  output logic signed [15:0]              r12,
  output logic signed [15:0]              r20,
  output logic signed [15:0]              r21,
  output logic signed [15:0]              r22,
  output logic                            bad_cmd
);

  logic                     push;
  logic                     full;
  logic                     q_valid;
  logic                     pop;
  eatr_pkg::item_t          f_item;
  eatr_pkg::item_t          q_item;
  eatr_pkg::fx_t [8:0]      res_m;

  eatr_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .angle_a(angle_a), .angle_b(angle_b), .angle_c(angle_c),
    .full(full), .push(push), .item(f_item)
  );

  eatr_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wr_item(f_item), .full(full),
    .pop(pop), .valid(q_valid), .rd_item(q_item)
  );

  eatr_back u_back (
    .clk(clk), .rst(rst), .valid(q_valid), .item(q_item), .pop(pop),
    .strobe(strobe), .res_m(res_m), .res_bad(bad_cmd)
  );

  assign r00 = res_m[0];
  assign r01 = res_m[1];
  assign r02 = res_m[2];
  assign r10 = res_m[3];
  assign r11 = res_m[4];
  assign r12 = res_m[5];
  assign r20 = res_m[6];
  assign r21 = res_m[7];
  assign r22 = res_m[8];

endmodule

### rtl/eatr_checker.sv
// Port-level checker for the rotation matrix unit, bound to the top level.
module eatr_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               strobe,
  input logic signed [15:0] r00,
  input logic signed [15:0] r01,
  input logic signed [15:0] r11,
  input logic signed [15:0] r22,
  input logic               bad_cmd
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##10 strobe)
    else $error("item accepted without a result ten cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 10))
    else $error("result without a matching accepted item");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    (strobe && bad_cmd) |-> (r00 == 16'sd16384 && r11 == 16'sd16384
                             && r22 == 16'sd16384 && r01 == 16'sd0))
    else $error("unknown command did not give the identity matrix");

  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (r00 <= 16'sd16384 && r00 >= -16'sd16384
                && r11 <= 16'sd16384 && r11 >= -16'sd16384))
    else $error("matrix element outside the unit range");

endmodule

bind euler_angles_to_rotation_matrix_unit eatr_checker u_eatr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .r00(r00), .r01(r01), .r11(r11), .r22(r22), .bad_cmd(bad_cmd)
);

### verif/rotation_matrix_checker.sv
// Checker: predicts each rotation matrix from the accepted item and compares every result.
`timescale 1ns / 1ps
module rotation_matrix_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [3:0]  cmd,
  input  logic [15:0] angle_a,
  input  logic [15:0] angle_b,
  input  logic [15:0] angle_c,
  input  logic        strobe,
  input  logic [15:0] r00,
  input  logic [15:0] r01,
  input  logic [15:0] r02,
  input  logic [15:0] r10,
  input  logic [15:0] r11,
  input  logic [15:0] r12,
  input  logic [15:0] r20,
  input  logic [15:0] r21,
  input  logic [15:0] r22,
  input  logic        bad_cmd,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic             bad;
    logic [8:0][15:0] r;
  } matrix_t;

  localparam longint ONE = 64'd16384;

  matrix_t matrix_q[$];

  function automatic longint sine_q14(logic [15:0] ang);
    longint unsigned f, z, z2, t, s, m;
    logic [1:0] q;
    q = ang[15:14];
    f = {50'd0, ang[13:0]};
    if (q[0]) begin
      f = 64'd16384 - f;
    end
    z  = f << 16;
    z2 = (z * z) >> 30;
    t  = (eatr_pkg::SIN_C * z2) >> 30;
    t  = eatr_pkg::SIN_B - t;
    t  = (t * z2) >> 30;
    t  = eatr_pkg::SIN_A - t;
    s  = (t * z) >> 30;
    m  = (s + 64'd32768) >> 16;
    if (m > 64'd16384) begin
      m = 64'd16384;
    end
    return q[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint cosine_q14(logic [15:0] ang);
    return sine_q14(ang + 16'd16384);
  endfunction

  function automatic longint pr(longint a, longint b);
    longint unsigned m;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 64'd8192) >> 14;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint pr3(longint a, longint b, longint c);
    return pr(pr(a, b), c);
  endfunction

  function automatic matrix_t rotation(logic [3:0] c, logic [15:0] a, logic [15:0] b,
                                       logic [15:0] g);
    longint m[9];
    longint sx, cx, sy, cy, sz, cz, v;
    matrix_t res;
    sx = sine_q14(a); cx = cosine_q14(a);
    sy = sine_q14(b); cy = cosine_q14(b);
    sz = sine_q14(g); cz = cosine_q14(g);
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    res.bad = 1'b0;
    case (eatr_pkg::cmd_e'(c))
      eatr_pkg::CMD_X: begin
        m[4] = cx; m[5] = sx; m[7] = -sx; m[8] = cx;
      end
      eatr_pkg::CMD_Y: begin
        m[0] = cx; m[2] = -sx; m[6] = sx; m[8] = cx;
      end
      eatr_pkg::CMD_Z: begin
        m[0] = cx; m[1] = sx; m[3] = -sx; m[4] = cx;
      end
      eatr_pkg::CMD_XYZ: begin
        m[0] = pr(cy, cz); m[1] = pr(cy, sz); m[2] = -sy;
        m[3] = pr3(sx, sy, cz) + pr(cx, -sz);
        m[4] = pr3(sx, sy, sz) + pr(cx, cz);
        m[5] = pr(sx, cy);
        m[6] = pr3(cx, sy, cz) + pr(sx, sz);
        m[7] = pr3(cx, sy, sz) + pr(-sx, cz);
        m[8] = pr(cx, cy);
      end
      eatr_pkg::CMD_XZY: begin
        m[0] = pr(cz, cy); m[1] = sz; m[2] = pr(cz, -sy);
        m[3] = pr3(cx, -sz, cy) + pr(sx, sy);
        m[4] = pr(cx, cz);
        m[5] = pr3(cx, -sz, -sy) + pr(sx, cy);
        m[6] = pr3(-sx, -sz, cy) + pr(cx, sy);
        m[7] = pr(-sx, cz);
        m[8] = pr3(-sx, -sz, -sy) + pr(cx, cy);
      end
      eatr_pkg::CMD_YXZ: begin
        m[0] = pr(cy, cz) + pr3(-sy, -sx, -sz);
        m[1] = pr(cy, sz) + pr3(-sy, -sx, cz);
        m[2] = pr(-sy, cx);
        m[3] = pr(cx, -sz); m[4] = pr(cx, cz); m[5] = sx;
        m[6] = pr(sy, cz) + pr3(cy, -sx, -sz);
        m[7] = pr(sy, sz) + pr3(cy, -sx, cz);
        m[8] = pr(cy, cx);
      end
      eatr_pkg::CMD_YZX: begin
        m[0] = pr(cy, cz);
        m[1] = pr3(cy, sz, cx) + pr(-sy, -sx);
        m[2] = pr3(cy, sz, sx) + pr(-sy, cx);
        m[3] = -sz; m[4] = pr(cz, cx); m[5] = pr(cz, sx);
        m[6] = pr(sy, cz);
        m[7] = pr3(sy, sz, cx) + pr(cy, -sx);
        m[8] = pr3(sy, sz, sx) + pr(cy, cx);
      end
      eatr_pkg::CMD_ZXY: begin
        m[0] = pr(cz, cy) + pr3(sz, sx, sy);
        m[1] = pr(sz, cx);
        m[2] = pr(cz, -sy) + pr3(sz, sx, cy);
        m[3] = pr(-sz, cy) + pr3(cz, sx, sy);
        m[4] = pr(cz, cx);
        m[5] = pr(-sz, -sy) + pr3(cz, sx, cy);
        m[6] = pr(cx, sy); m[7] = -sx; m[8] = pr(cx, cy);
      end
      eatr_pkg::CMD_ZYX: begin
        m[0] = pr(cz, cy);
        m[1] = pr(sz, cx) + pr3(cz, -sy, -sx);
        m[2] = pr(sz, sx) + pr3(cz, -sy, cx);
        m[3] = pr(-sz, cy);
        m[4] = pr(cz, cx) + pr3(-sz, -sy, -sx);
        m[5] = pr(cz, sx) + pr3(-sz, -sy, cx);
        m[6] = sy; m[7] = pr(cy, -sx); m[8] = pr(cy, cx);
      end
      default: begin
        res.bad = 1'b1;
      end
    endcase
    for (int j = 0; j < 9; j++) begin
      v = m[j];
      if (v > ONE) v = ONE;
      if (v < -ONE) v = -ONE;
      res.r[j] = v[15:0];
    end
    return res;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    matrix_t want;
    matrix_t got;
    if (!rst) begin
      if (strobe) begin
        got.bad = bad_cmd;
        got.r   = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
        if (matrix_q.size() == 0) begin
          $display("%0t: result with none expected", $time);
          errors++;
        end else begin
          want = matrix_q.pop_front();
          for (int j = 0; j < 9; j++) begin
            if (got.r[j] !== want.r[j]) begin
              $display("%0t: r%0d%0d expected %0d actual %0d", $time, j / 3, j % 3,
                       $signed(want.r[j]), $signed(got.r[j]));
              errors++;
            end
          end
          if (got.bad !== want.bad) begin
            $display("%0t: bad_cmd expected %0b actual %0b", $time, want.bad, got.bad);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        matrix_q.push_back(rotation(cmd, angle_a, angle_b, angle_c));
      end
      pending = matrix_q.size();
    end
  end
endmodule

### verif/tb.sv
// Testbench top: drives command items into the rotation matrix unit and gives the verdict.
`timescale 1ns / 1ps
module tb;
  localparam int LIMIT      = 200000;
  localparam int NUM_RANDOM = 1500;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  cmd;
  logic [15:0] angle_a;
  logic [15:0] angle_b;
  logic [15:0] angle_c;
  logic        strobe;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic        bad_cmd;
  int          errors;
  int          pending;
  int          cycles;
  int          n_items;

  euler_angles_to_rotation_matrix_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .angle_a(angle_a), .angle_b(angle_b), .angle_c(angle_c), .strobe(strobe),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22), .bad_cmd(bad_cmd)
  );

  rotation_matrix_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .angle_a(angle_a), .angle_b(angle_b), .angle_c(angle_c), .strobe(strobe),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22), .bad_cmd(bad_cmd),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_angle();
    logic [15:0] specials[8] = '{16'd0, 16'd16384, 16'd32768, 16'd49152,
                                 16'd65535, 16'd8192, 16'd16383, 16'd1};
    if ($urandom_range(0, 5) == 0) begin
      return specials[$urandom_range(0, 7)];
    end
    return 16'($urandom);
  endfunction

  task automatic issue(logic [3:0] c, logic [15:0] a, logic [15:0] b, logic [15:0] g,
                       bit allow_idle);
    if (allow_idle && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= c;
    angle_a <= a;
    angle_b <= b;
    angle_c <= g;
    do @(posedge clk); while (busy);
    n_items++;
  endtask

  initial begin
    logic [3:0] c;
    rst     = 1'b1;
    start   = 1'b0;
    cmd     = '0;
    angle_a = '0;
    angle_b = '0;
    angle_c = '0;
    n_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every command, valid and unknown, with quarter-turn and all-ones angles.
    for (int k = 0; k < 16; k++) begin
      issue(4'(k), 16'd16384 * 16'(k % 4), 16'd65535 - 16'(k), 16'd8192 * 16'(k % 8), 1'b1);
    end
    issue(eatr_pkg::CMD_X, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    issue(eatr_pkg::CMD_XYZ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    issue(eatr_pkg::CMD_ZYX, 16'd32768, 16'd49152, 16'd16384, 1'b1);
    issue(eatr_pkg::CMD_YXZ, 16'd16383, 16'd1, 16'd49151, 1'b1);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = 4'($urandom_range(9, 15));
      end else begin
        c = 4'($urandom_range(0, 8));
      end
      issue(c, pick_angle(), pick_angle(), pick_angle(), !(k >= 600 && k < 900));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items: all single-axis and Euler orders, unknown commands,", n_items);
    $display("quarter-turn and extreme angles, with random gaps on the start side.");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/eatr_pkg.sv
rtl/eatr_front.sv
rtl/eatr_fifo.sv
rtl/eatr_sine.sv
rtl/eatr_back.sv
rtl/euler_angles_to_rotation_matrix_unit.sv
rtl/eatr_checker.sv
verif/rotation_matrix_checker.sv
verif/tb.sv
